// File: hdl/wsjq_pkg.sv
package wsjq_pkg;

  // default geometry
  localparam int QUEUES_DEF      = 8;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int JOB_SLOTS_DEF   = 64;

  // request kinds
  localparam logic [1:0] FN_CREATE = 2'd0;
  localparam logic [1:0] FN_PUSH   = 2'd1;
  localparam logic [1:0] FN_POP    = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic exec;
    logic finish_pop;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic is_pop;
    logic pop_found;
  } stat_t;

endpackage

// File: hdl/work_stealing_job_queues.sv
// work-stealing job queues: one fifo of job handles per thread plus a
// ring counter of job slots
// input channel (in_valid/in_ready): one request transaction carrying
//   in_func (create, push, pop), in_thread_id and in_job_handle
// result channel (out_valid/out_ready): exactly one result transaction per
//   request with out_status, out_job_out and out_source_queue
// one request is in work at a time; in_ready is high only while idle
// steps to out_valid: create, push, unknown kinds and a pop that finds
//   no job write the result from the execute step; a pop that finds a
//   job adds a read-data step for the registered read of the job store
// a new request is accepted only once the last one leaves its last step
// a result waits in the output register; the next request is accepted
//   meanwhile and holds in its execute step until that register frees up
// reset (rst_n low, synchronous) empties all queues and zeroes the slot
//   counter; the store itself is not cleared, only held entries are read
module work_stealing_job_queues #(
  parameter int QUEUES      = wsjq_pkg::QUEUES_DEF,
  parameter int QUEUE_DEPTH = wsjq_pkg::QUEUE_DEPTH_DEF,
  parameter int JOB_SLOTS   = wsjq_pkg::JOB_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_func,
  input  logic [2:0] in_thread_id,
  input  logic [5:0] in_job_handle,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [5:0] out_job_out,
  output logic [2:0] out_source_queue
);

  // command and status between sequencer and datapath
  wsjq_pkg::cmd_t  cmd;
  wsjq_pkg::stat_t stat;

  // sequencer: idle, execute, read-data
  wsjq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // queue pointers, job store, slot counter and result register
  wsjq_dp #(
    .QUEUES      (QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .JOB_SLOTS   (JOB_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_func          (in_func),
    .in_thread_id     (in_thread_id),
    .in_job_handle    (in_job_handle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_job_out      (out_job_out),
    .out_source_queue (out_source_queue)
  );

endmodule

// File: hdl/wsjq_ctrl.sv
module wsjq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  wsjq_pkg::stat_t stat,
  output wsjq_pkg::cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_RDATA = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    in_ready       = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = (stat.is_pop && stat.pop_found) ? S_RDATA : S_IDLE;
        end
      end
      S_RDATA: begin
        if (stat.out_free) begin
          cmd.finish_pop = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hdl/wsjq_dp.sv
module wsjq_dp #(
  parameter int QUEUES      = wsjq_pkg::QUEUES_DEF,
  parameter int QUEUE_DEPTH = wsjq_pkg::QUEUE_DEPTH_DEF,
  parameter int JOB_SLOTS   = wsjq_pkg::JOB_SLOTS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  wsjq_pkg::cmd_t  cmd,
  output wsjq_pkg::stat_t stat,
  input  logic [1:0]      in_func,
  input  logic [2:0]      in_thread_id,
  input  logic [5:0]      in_job_handle,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_status,
  output logic [5:0]      out_job_out,
  output logic [2:0]      out_source_queue
);

  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
  localparam int MEM_DEPTH = QUEUES << PW;

  // request register
  logic [1:0] func_r;
  logic [2:0] tid_r;
  logic [5:0] handle_r;

  logic [PW-1:0] head_r  [QUEUES];
  logic [PW-1:0] tail_r  [QUEUES];
  logic [CW-1:0] count_r [QUEUES];
  logic [SW-1:0] slot_r;

  logic [5:0] mem [MEM_DEPTH];
  logic [5:0] rd_r;

  logic       out_valid_r;
  logic [1:0] out_status_r;
  logic [5:0] out_job_r;
  logic [2:0] out_src_r;

  logic          own_ok;
  logic [QW-1:0] own_idx;
  logic [QUEUES-1:0] nonempty, steal_mask;
  logic [QW-1:0] pick_q;
  logic          pick_found;
  logic          push_ok;
  logic          do_push, do_pop;

  always_comb begin
    own_ok  = (32'(tid_r) < QUEUES);
    own_idx = QW'(tid_r);
    for (int q = 0; q < QUEUES; q++) begin
      nonempty[q] = (count_r[q] != '0);
    end
    steal_mask = nonempty;
    if (own_ok) begin
      steal_mask[own_idx] = 1'b0;
    end
    // lowest-numbered other nonempty queue
    pick_q     = '0;
    pick_found = 1'b0;
    for (int q = QUEUES - 1; q >= 0; q--) begin
      if (steal_mask[q]) begin
        pick_q     = QW'(q);
        pick_found = 1'b1;
      end
    end
    // own queue first
    if (own_ok && nonempty[own_idx]) begin
      pick_q     = own_idx;
      pick_found = 1'b1;
    end
    push_ok = own_ok && (count_r[own_idx] != CW'(QUEUE_DEPTH));
  end

  assign do_push = cmd.exec && (func_r == wsjq_pkg::FN_PUSH) && push_ok;
  assign do_pop  = cmd.exec && (func_r == wsjq_pkg::FN_POP) && pick_found;

  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.is_pop    = (func_r == wsjq_pkg::FN_POP);
  assign stat.pop_found = pick_found;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      func_r   <= in_func;
      tid_r    <= in_thread_id;
      handle_r <= in_job_handle;
    end
  end

  // job store, one region per queue
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[{own_idx, tail_r[own_idx]}] <= handle_r;
    end
    if (do_pop) begin
      rd_r <= mem[{pick_q, head_r[pick_q]}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int q = 0; q < QUEUES; q++) begin
        head_r[q]  <= '0;
        tail_r[q]  <= '0;
        count_r[q] <= '0;
      end
      slot_r <= '0;
    end else if (cmd.exec) begin
      if (func_r == wsjq_pkg::FN_CREATE) begin
        slot_r <= (slot_r == SW'(JOB_SLOTS - 1)) ? '0 : slot_r + 1'b1;
      end
      if (do_push) begin
        tail_r[own_idx]  <= (tail_r[own_idx] == PW'(QUEUE_DEPTH - 1)) ? '0
                            : tail_r[own_idx] + 1'b1;
        count_r[own_idx] <= count_r[own_idx] + 1'b1;
      end
      if (do_pop) begin
        head_r[pick_q]  <= (head_r[pick_q] == PW'(QUEUE_DEPTH - 1)) ? '0
                           : head_r[pick_q] + 1'b1;
        count_r[pick_q] <= count_r[pick_q] - 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish_pop || (cmd.exec && !do_pop)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_pop) begin
      out_status_r <= wsjq_pkg::ST_OK;
      out_job_r    <= rd_r;
    end else if (cmd.exec) begin
      out_status_r <= wsjq_pkg::ST_OK;
      out_job_r    <= '0;
      out_src_r    <= '0;
      case (func_r)
        wsjq_pkg::FN_CREATE: out_job_r <= 6'(slot_r);
        wsjq_pkg::FN_PUSH: begin
          if (!push_ok) out_status_r <= wsjq_pkg::ST_FULL;
        end
        wsjq_pkg::FN_POP: begin
          if (!pick_found) out_status_r <= wsjq_pkg::ST_EMPTY;
          else out_src_r <= 3'(pick_q);
        end
        default: ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_job_out      = out_job_r;
  assign out_source_queue = out_src_r;

endmodule

// File: hdl/wsjq_chk.sv
module wsjq_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic [5:0] out_job_out,
  input logic [2:0] out_source_queue
);

  // a stalled result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one request in work at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted back to back");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == wsjq_pkg::ST_OK || out_status == wsjq_pkg::ST_EMPTY ||
                   out_status == wsjq_pkg::ST_FULL))
    else $error("bad status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != wsjq_pkg::ST_OK |-> out_job_out == '0 &&
    out_source_queue == '0)
    else $error("failed request returns nonzero payload");

endmodule

bind work_stealing_job_queues wsjq_chk u_chk (.*);

// File: bench/testbench.sv
module testbench;

  // no package code for the unused request kind
  localparam logic [1:0] FN_UNKNOWN = 2'd3;

  localparam int DIRECTED_ITEMS = 25;
  localparam int RANDOM_ITEMS   = 1400;
  localparam int SEGMENT_ITEMS  = 40;    // random items that share one push/pop mix
  localparam int QUIET_ITEMS    = 200;   // last part of the run, no idling
  localparam int LONG_HOLD      = 100;   // receiver hold-off to back the block up
  localparam int HOLD_AFTER     = 400;   // results seen before the hold-off starts
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] thread;
    logic [5:0] handle;
  } request_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] job;
    logic [2:0] source;
  } job_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_func = '0;
  logic [2:0] in_thread_id = '0;
  logic [5:0] in_job_handle = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_status;
  logic [5:0] out_job_out;
  logic [2:0] out_source_queue;

  work_stealing_job_queues u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_thread_id     (in_thread_id),
    .in_job_handle    (in_job_handle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_job_out      (out_job_out),
    .out_source_queue (out_source_queue)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // requests waiting to be offered, and results waiting to come out
  request_t    pending_requests[$];
  job_result_t expected_results[$];

  // shadow of the scheduler state: per-thread ring buffers and the slot counter
  logic [5:0] q_store[wsjq_pkg::QUEUES_DEF][wsjq_pkg::QUEUE_DEPTH_DEF];
  logic [3:0] q_head[wsjq_pkg::QUEUES_DEF];
  logic [3:0] q_tail[wsjq_pkg::QUEUES_DEF];
  logic [4:0] q_count[wsjq_pkg::QUEUES_DEF];
  logic [5:0] next_slot;

  int   errors = 0;
  int   results_seen = 0;
  int   idle_cycles = 0;
  int   send_gap = 0;
  int   ready_gap = 0;
  int   hold_left = 0;
  logic held_once = 1'b0;
  logic tail_phase = 1'b0;

  // apply one request to the shadow state and return the result it must produce
  function automatic job_result_t schedule_request(request_t r);
    job_result_t res;
    int          src;
    res = '{wsjq_pkg::ST_OK, 6'd0, 3'd0};
    src = -1;
    case (r.kind)
      wsjq_pkg::FN_CREATE: begin
        res.job = next_slot;
        next_slot = 6'((next_slot + 1) % wsjq_pkg::JOB_SLOTS_DEF);
      end
      wsjq_pkg::FN_PUSH: begin
        // full own queue (or a thread without a queue) is flagged, nothing stored
        if (r.thread >= wsjq_pkg::QUEUES_DEF ||
            q_count[r.thread] >= wsjq_pkg::QUEUE_DEPTH_DEF) begin
          res.status = wsjq_pkg::ST_FULL;
        end else begin
          q_store[r.thread][q_tail[r.thread]] = r.handle;
          q_tail[r.thread] = 4'((q_tail[r.thread] + 1) % wsjq_pkg::QUEUE_DEPTH_DEF);
          q_count[r.thread] = q_count[r.thread] + 5'd1;
        end
      end
      wsjq_pkg::FN_POP: begin
        // own queue first, else steal from the lowest-numbered non-empty one
        if (r.thread < wsjq_pkg::QUEUES_DEF && q_count[r.thread] != 0) begin
          src = r.thread;
        end else begin
          for (int q = 0; q < wsjq_pkg::QUEUES_DEF; q++)
            if (src < 0 && q != r.thread && q_count[q] != 0) src = q;
        end
        if (src < 0) begin
          res.status = wsjq_pkg::ST_EMPTY;
        end else begin
          res.job    = q_store[src][q_head[src]];
          res.source = src[2:0];
          q_head[src]  = 4'((q_head[src] + 1) % wsjq_pkg::QUEUE_DEPTH_DEF);
          q_count[src] = q_count[src] - 5'd1;
        end
      end
      default: ;  // unknown kind: no state change, all-zero result
    endcase
    return res;
  endfunction

  task automatic add_request(logic [1:0] kind, logic [2:0] thread, logic [5:0] handle);
    pending_requests.push_back('{kind, thread, handle});
  endtask

  // request driver: offers queued transactions with random gaps
  always @(posedge clk) begin
    request_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
      next_slot = '0;
      for (int q = 0; q < wsjq_pkg::QUEUES_DEF; q++) begin
        q_head[q]  = '0;
        q_tail[q]  = '0;
        q_count[q] = '0;
      end
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(
          schedule_request('{in_func, in_thread_id, in_job_handle}));
      // the valid slot frees up when nothing is offered or the offer was taken
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_requests.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else begin
          nxt = pending_requests.pop_front();
          in_valid      <= 1'b1;
          in_func       <= nxt.kind;
          in_thread_id  <= nxt.thread;
          in_job_handle <= nxt.handle;
        end
      end
      tail_phase <= (pending_requests.size() < QUIET_ITEMS);
    end
  end

  // result receiver: random stalls plus one long hold-off so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_gap <= 0;
      hold_left <= 0;
    end else if (!held_once && results_seen >= HOLD_AFTER) begin
      held_once <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= (hold_left == 1);
    end else if (ready_gap != 0) begin
      ready_gap <= ready_gap - 1;
      out_ready <= 1'b0;
    end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
      ready_gap <= $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    job_result_t exp_res;
    int          bad;
    bad = 0;
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d job=%0d source=%0d",
                 $time, out_status, out_job_out, out_source_queue);
        bad = bad + 1;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_status !== exp_res.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_res.status, out_status);
          bad = bad + 1;
        end
        if (out_job_out !== exp_res.job) begin
          $display("%0t: job_out expected %0d actual %0d", $time, exp_res.job, out_job_out);
          bad = bad + 1;
        end
        if (out_source_queue !== exp_res.source) begin
          $display("%0t: source_queue expected %0d actual %0d",
                   $time, exp_res.source, out_source_queue);
          bad = bad + 1;
        end
      end
      errors <= errors + bad;
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int          push_pct;
    int          roll;
    logic [2:0]  hot_thread;
    logic [1:0]  kind;
    logic [2:0]  thread;

    // directed part
    add_request(wsjq_pkg::FN_POP, 3'd2, 6'd0);     // pop with every queue empty
    add_request(wsjq_pkg::FN_CREATE, 3'd0, 6'd0);
    add_request(FN_UNKNOWN, 3'd7, 6'd63);          // unknown kind changes nothing
    add_request(wsjq_pkg::FN_PUSH, 3'd7, 6'd63);
    add_request(wsjq_pkg::FN_PUSH, 3'd0, 6'd0);
    add_request(wsjq_pkg::FN_POP, 3'd7, 6'd21);    // own queue, handle field ignored
    add_request(wsjq_pkg::FN_POP, 3'd3, 6'd0);     // steals from queue 0
    for (int i = 0; i < wsjq_pkg::QUEUE_DEPTH_DEF; i++)
      add_request(wsjq_pkg::FN_PUSH, 3'd5, 6'(i * 4 + 1));
    add_request(wsjq_pkg::FN_PUSH, 3'd5, 6'd42);   // queue 5 full
    add_request(wsjq_pkg::FN_POP, 3'd5, 6'd0);

    // random part: segments with a shifting push/pop mix, often around one hot thread
    while (pending_requests.size() < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      push_pct   = $urandom_range(10, 90);
      hot_thread = 3'($urandom_range(0, 7));
      for (int k = 0; k < SEGMENT_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8)
          kind = wsjq_pkg::FN_CREATE;
        else if (roll < 11)
          kind = FN_UNKNOWN;
        else if ($urandom_range(0, 99) < push_pct)
          kind = wsjq_pkg::FN_PUSH;
        else
          kind = wsjq_pkg::FN_POP;
        thread = $urandom_range(0, 1) ? hot_thread : 3'($urandom_range(0, 7));
        add_request(kind, thread, 6'($urandom_range(0, 63)));
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // wait for all requests to go out and every result to come back
    while (!(pending_requests.size() == 0 && !in_valid && expected_results.size() == 0)
           && idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk);

    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding",
               $time, expected_results.size());
      $display("RESULT: ERROR");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (errors == 0)
        $display("RESULT: OK");
      else
        $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
